// ===== rtl/gss_pkg.sv =====
package gss_pkg;

  localparam int FRACTION_BITS = 16;

  // golden ratio conjugate as unsigned q0.30
  localparam int          GOLD_SHIFT = 30;
  localparam logic [31:0] GOLD_Q30   = 32'd663608942;
  // 100 * (1 - ratio) as unsigned q.16
  localparam logic [31:0] ERR_K      = 32'd2503252;

  localparam int          QUOT_W  = 31;
  localparam int          DIVD_W  = 54;
  localparam int          PROD_W  = 64;
  localparam logic [QUOT_W-1:0] ERR_MAX = '1;

  localparam logic [7:0]        MAX_ITER_RST = 8'd100;
  localparam logic [QUOT_W-1:0] TOL_RST      = 31'd65536;

  localparam logic CFG_MAX_ITER = 1'b0;
  localparam logic CFG_TOL      = 1'b1;

  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [31:0]       divisor;
  } div_req_t;

endpackage

// ===== rtl/golden_section_search.sv =====
// golden-section search on f(x) = -x*x in signed q16.16
// input beats carry the interval bounds in in_tdata and the goal in in_tuser
// (0 maximise, 1 minimise); one result beat is produced per input beat
// with the midpoint, its objective value, the exit iteration index and the
// relative error in percent
// max_iterations and tolerance are written through the cfg port; the user must
// write them only while idle, as the block itself has no guard against it
// each iteration uses the one shared 32x32 multiplier (interior offset, error
// numerator, tolerance bound); the exit check compares against a tolerance
// product so no divide runs per iteration; after the last iteration a
// bit-serial divider forms the reported error while the multiplier squares
// the midpoint; the divide is skipped when the error saturates or when no
// iteration runs; at most max_iterations iterations are run, and in_tready is
// high only while no item is in work
// reset clears the sequencer and output valid and loads max_iterations = 100
// and tolerance = 1.0 percent
// a stalled result holds in the output register; the next item may be
// accepted while it waits, but its own result is not loaded until the
// previous one has been taken
module golden_section_search import gss_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // lower_bound, upper_bound
  input  logic         in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // best_point, best_value, iterations_used, error_estimate
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [30:0]  cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MID  = 4'd1;
  localparam logic [3:0] S_XPT  = 4'd2;
  localparam logic [3:0] S_UPD  = 4'd3;
  localparam logic [3:0] S_SPN  = 4'd4;
  localparam logic [3:0] S_TOL  = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;

  logic [3:0]        state_r;
  logic [31:0]       lo_r;
  logic [31:0]       hi_r;
  logic              kind_r;
  logic [31:0]       mid_r;
  logic              sgn_r;
  logic [32:0]       x1_r;
  logic [32:0]       x2_r;
  logic [DIVD_W-1:0] p_r;
  logic [7:0]        j_r;
  logic              have_err_r;
  logic [7:0]        max_iter_r;
  logic [QUOT_W-1:0] tol_r;
  logic              out_valid_r;
  logic [103:0]      out_data_r;

  mul_req_t          mul_req;
  div_req_t          div_req;
  logic [PROD_W-1:0] prod_r;
  logic              div_busy;
  logic [QUOT_W-1:0] div_quot;

  logic [32:0]       span_diff;
  logic [32:0]       span_neg;
  logic [31:0]       span_mag;
  logic [31:0]       mid_mag;
  logic [31:0]       mid_new;
  logic [31:0]       mid_in;
  logic [PROD_W-1:0] d_rnd;
  logic [31:0]       d_mag;
  logic [32:0]       d_val;
  logic [32:0]       a1;
  logic [32:0]       a2;
  logic              first_better;
  logic [31:0]       tol1;
  logic              brk;
  logic [PROD_W-1:0] sq_rnd;
  logic [47:0]       mag_val;
  logic [31:0]       value;
  logic [QUOT_W-1:0] err;
  logic              load_out;

  function automatic logic [31:0] half_floor(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    return s[32:1];
  endfunction

  always_comb begin
    span_diff = {hi_r[31], hi_r} - {lo_r[31], lo_r};
    span_neg  = ~span_diff + 33'd1;
    span_mag  = span_diff[32] ? span_neg[31:0] : span_diff[31:0];
    mid_mag   = mid_r[31] ? (~mid_r + 32'd1) : mid_r;
    mid_new   = half_floor(lo_r, hi_r);
    mid_in    = half_floor(in_tdata[31:0], in_tdata[63:32]);

    // interior offset, rounded half up in magnitude
    d_rnd = prod_r + (PROD_W'(1) << (GOLD_SHIFT - 1));
    d_mag = d_rnd[GOLD_SHIFT +: 32];
    d_val = sgn_r ? (~{1'b0, d_mag} + 33'd1) : {1'b0, d_mag};

    a1 = x1_r[32] ? (~x1_r + 33'd1) : x1_r;
    a2 = x2_r[32] ? (~x2_r + 33'd1) : x2_r;
    first_better = kind_r ? (a1 > a2) : (a1 < a2);

    // err <= tol  <=>  p < (tol + 1) * |mid|, or tol at full scale
    tol1 = {1'b0, tol_r} + 32'd1;
    brk  = (tol_r == ERR_MAX) || (PROD_W'(p_r) < prod_r);

    sq_rnd  = prod_r + (PROD_W'(1) << (FRACTION_BITS - 1));
    mag_val = sq_rnd[FRACTION_BITS +: 48];
    value   = (mag_val > 48'h0000_8000_0000) ? 32'h8000_0000 : (32'd0 - mag_val[31:0]);
    err     = have_err_r ? div_quot : '0;

    load_out = (state_r == S_DIV) && !div_busy && (!out_valid_r || out_tready);
  end

  always_comb begin
    mul_req = '0;
    unique case (state_r)
      S_MID: begin
        mul_req = '{en: 1'b1, a: span_mag, b: GOLD_Q30};
      end
      S_SPN: begin
        mul_req = '{en: 1'b1, a: span_mag, b: ERR_K};
      end
      S_TOL: begin
        mul_req = '{en: 1'b1, a: tol1, b: mid_mag};
      end
      S_FIN: begin
        mul_req = '{en: 1'b1, a: mid_mag, b: mid_mag};
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  always_comb begin
    div_req.start    = (state_r == S_FIN) && have_err_r;
    div_req.dividend = p_r;
    div_req.divisor  = mid_mag;
  end

  gss_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod_r)
  );

  gss_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (div_req),
    .busy_r (div_busy),
    .quot_r (div_quot)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= MAX_ITER_RST;
      tol_r      <= TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_ITER: max_iter_r <= cfg_data[7:0];
        CFG_TOL:      tol_r      <= cfg_data;
        default:      tol_r      <= tol_r;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      have_err_r  <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {1'b0, err, j_r, value, mid_r};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            lo_r       <= in_tdata[31:0];
            hi_r       <= in_tdata[63:32];
            kind_r     <= in_tuser;
            mid_r      <= mid_in;
            j_r        <= '0;
            have_err_r <= 1'b0;
            state_r    <= (max_iter_r == '0) ? S_FIN : S_MID;
          end
        end
        S_MID: begin
          mid_r   <= mid_new;
          sgn_r   <= span_diff[32];
          state_r <= S_XPT;
        end
        S_XPT: begin
          x1_r    <= {lo_r[31], lo_r} + d_val;
          x2_r    <= {hi_r[31], hi_r} - d_val;
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (first_better) begin
            lo_r <= x2_r[31:0];
          end else begin
            hi_r <= x1_r[31:0];
          end
          state_r <= S_SPN;
        end
        S_SPN: begin
          state_r <= S_TOL;
        end
        S_TOL: begin
          p_r     <= prod_r[DIVD_W-1:0];
          state_r <= S_CHK;
        end
        S_CHK: begin
          have_err_r <= 1'b1;
          if (brk) begin
            state_r <= S_FIN;
          end else begin
            j_r     <= j_r + 8'd1;
            state_r <= ((j_r + 8'd1) == max_iter_r) ? S_FIN : S_MID;
          end
        end
        S_FIN: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready again straight after accepting a beat");

  a_result_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_DIV))
    else $error("result raised outside the final step");
`endif

endmodule

// ===== rtl/gss_mul.sv =====
module gss_mul import gss_pkg::*; (
  input  logic              clk,
  input  mul_req_t          req,
  output logic [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= PROD_W'(req.a) * PROD_W'(req.b);
    end
  end

endmodule

// ===== rtl/gss_div.sv =====
module gss_div import gss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  div_req_t          req,
  output logic              busy_r,
  output logic [QUOT_W-1:0] quot_r
);

  logic [31:0]       rem_r;
  logic [31:0]       den_r;
  logic [QUOT_W-1:0] bits_r;
  logic [4:0]        cnt_r;
  logic [32:0]       r2;
  logic [32:0]       diff;
  logic              ge;
  logic              sat;

  always_comb begin
    r2   = {rem_r, bits_r[QUOT_W-1]};
    diff = r2 - {1'b0, den_r};
    ge   = r2 >= {1'b0, den_r};
    // quotient would not fit in 31 bits
    sat  = (req.divisor == '0) ||
           (32'(req.dividend[DIVD_W-1:QUOT_W]) >= req.divisor);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      if (sat) begin
        busy_r <= 1'b0;
        quot_r <= ERR_MAX;
      end else begin
        busy_r <= 1'b1;
        quot_r <= '0;
        rem_r  <= 32'(req.dividend[DIVD_W-1:QUOT_W]);
        bits_r <= req.dividend[QUOT_W-1:0];
        den_r  <= req.divisor;
        cnt_r  <= 5'(QUOT_W - 1);
      end
    end else if (busy_r) begin
      rem_r  <= ge ? diff[31:0] : r2[31:0];
      quot_r <= {quot_r[QUOT_W-2:0], ge};
      bits_r <= {bits_r[QUOT_W-2:0], 1'b0};
      cnt_r  <= cnt_r - 5'd1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < den_r)
    else $error("divider remainder not below divisor");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");
`endif

endmodule
